// File: sv/stc_pkg.sv
// ----------------------------------------------------------------------------
// stc_pkg
// Shared types and constants of the sorted table core: beat layouts,
// operation and status codes, and the control that drives the cell chain.
// ----------------------------------------------------------------------------
package stc_pkg;

    localparam int MAX_RESULTS = 64;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_SEARCH = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_DUMP   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_EMPTY     = 2'd3
    } t_status;

    // register index of the configuration space
    localparam logic CFG_IDX_CAPACITY = 1'b0;
    localparam logic [6:0] CAPACITY_RESET = 7'd64;

    typedef struct packed {
        t_kind              kind;
        logic signed [31:0] value;
    } t_in_beat;

    typedef struct packed {
        t_status            status;
        logic [5:0]         position;
        logic signed [31:0] entry_value;
        logic [6:0]         entry_count;
        logic               last;
    } t_out_beat;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2,
        CELL_ROTATE = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op           op;
        logic signed [31:0] value;
    } t_cell_ctrl;

    typedef struct packed {
        logic above;     // empty, or holds a value greater than the operand
        logic at_after;  // held, and value not below the operand
        logic equal;     // held, and value equals the operand
    } t_cell_flags;

endpackage

// File: sv/stc_cell.sv
// ----------------------------------------------------------------------------
// stc_cell
// One slot of the sorted chain: holds a value, compares it with the broadcast
// operand and takes its own, either neighbor's, the operand or the head's value.
// ----------------------------------------------------------------------------
module stc_cell (
    input  logic                     i_clk,
    input  stc_pkg::t_cell_ctrl      i_ctrl,
    input  logic                     i_valid,
    input  logic                     i_wrap,
    input  logic                     i_left_above,
    input  logic signed [31:0]       i_left_val,
    input  logic signed [31:0]       i_right_val,
    input  logic signed [31:0]       i_wrap_val,
    output stc_pkg::t_cell_flags     o_flags,
    output logic signed [31:0]       o_val
);
    import stc_pkg::*;

    logic signed [31:0] r_val;
    logic signed [31:0] n_val;

    assign o_flags.above    = !i_valid || (r_val > i_ctrl.value);
    assign o_flags.at_after = i_valid && (r_val >= i_ctrl.value);
    assign o_flags.equal    = i_valid && (r_val == i_ctrl.value);
    assign o_val            = r_val;

    always_comb begin
        n_val = r_val;
        case (i_ctrl.op)
            CELL_INSERT: begin
                // cells at or above the insert point move up one slot
                if (o_flags.above) begin
                    n_val = i_left_above ? i_left_val : i_ctrl.value;
                end
            end
            CELL_REMOVE: begin
                if (o_flags.at_after) begin
                    n_val = i_right_val;
                end
            end
            CELL_ROTATE: begin
                // rotate held entries left, head goes to the last held slot
                if (i_wrap) begin
                    n_val = i_wrap_val;
                end else if (i_valid) begin
                    n_val = i_right_val;
                end
            end
            default: begin
                n_val = r_val;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

// File: sv/sorted_table_insert_search_remove_core.sv
// ----------------------------------------------------------------------------
// sorted_table_insert_search_remove_core
// Sorted table of signed 32-bit values kept in a chain of compare-and-shift
// cells, with insert, search, remove and dump, and a capacity register.
// ----------------------------------------------------------------------------
// For insert, search and remove every cell compares its entry with the operand
// at once and shifts or holds in the same cycle, and the result beat is
// registered. In a dump the held entries rotate through the chain one slot a
// cycle unless a beat is due and the output is stalled, the head of the chain
// being sent out as a beat, so the table is back in order when the dump ends;
// only the first 64 entries are sent, larger tables finish their rotation
// without beats. A new item is taken when the block is not dumping and the
// output register is empty or being emptied. The table needs no clearing after
// reset. Capacity is written through the APB port at any address with paddr[2]
// clear; a capacity above DEPTH acts as DEPTH.
module sorted_table_insert_search_remove_core #(
    parameter int DEPTH = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  stc_pkg::t_in_beat    i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output stc_pkg::t_out_beat   o_out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import stc_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DUMP = 2'b10
    } t_state;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_k, n_k;
    logic [6:0]         r_capacity;
    logic               r_out_valid, n_out_valid;
    t_out_beat          r_out, n_out;

    t_cell_ctrl         w_ctrl;
    t_cell_flags        w_flags [DEPTH];
    logic signed [31:0] w_val   [DEPTH];
    logic [DEPTH-1:0]   w_valid;
    logic [DEPTH-1:0]   w_wrap;

    logic               w_in_fire;
    logic               w_out_free;
    logic               w_full;
    logic               w_found;
    logic [IW-1:0]      w_ins_pos;
    logic [IW-1:0]      w_hit_pos;
    int                 w_cap;
    int                 w_lim;
    logic               w_emit;

    // ---- cell chain ----
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic               w_left_above;
        logic signed [31:0] w_left_val;
        logic signed [31:0] w_right_val;

        assign w_valid[g] = (32'(r_count) > g);
        assign w_wrap[g]  = (32'(r_count) == g + 1);

        if (g == 0) begin : g_head
            assign w_left_above = 1'b0;
            assign w_left_val   = '0;
        end else begin : g_body
            assign w_left_above = w_flags[g-1].above;
            assign w_left_val   = w_val[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_right_val = w_val[g];
        end else begin : g_mid
            assign w_right_val = w_val[g+1];
        end

        stc_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_valid      (w_valid[g]),
            .i_wrap       (w_wrap[g]),
            .i_left_above (w_left_above),
            .i_left_val   (w_left_val),
            .i_right_val  (w_right_val),
            .i_wrap_val   (w_val[0]),
            .o_flags      (w_flags[g]),
            .o_val        (w_val[g])
        );
    end

    // insert point and first match are both edges in a sorted chain
    always_comb begin
        w_ins_pos = '0;
        w_hit_pos = '0;
        w_found   = 1'b0;
        for (int i = 0; i < DEPTH; i++) begin
            if (w_flags[i].above && !(i > 0 && w_flags[(i > 0) ? i - 1 : 0].above)) begin
                w_ins_pos = w_ins_pos | IW'(i);
            end
            if (w_flags[i].equal && !(i > 0 && w_flags[(i > 0) ? i - 1 : 0].equal)) begin
                w_hit_pos = w_hit_pos | IW'(i);
            end
            w_found = w_found | w_flags[i].equal;
        end
    end

    assign w_cap      = (32'(r_capacity) > DEPTH) ? DEPTH : 32'(r_capacity);
    assign w_full     = (32'(r_count) >= w_cap);
    assign w_lim      = (32'(r_count) > MAX_RESULTS) ? MAX_RESULTS : 32'(r_count);
    assign w_emit     = (32'(r_k) < MAX_RESULTS);
    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && w_out_free;
    assign w_in_fire  = i_in_valid && o_in_ready;

    always_comb begin
        w_ctrl.op    = CELL_HOLD;
        w_ctrl.value = i_in_data.value;
        n_state      = r_state;
        n_count      = r_count;
        n_k          = r_k;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out        = r_out;
        case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    n_out_valid           = 1'b1;
                    n_out.status          = STAT_OK;
                    n_out.position        = '0;
                    n_out.entry_value     = i_in_data.value;
                    n_out.entry_count     = 7'(r_count);
                    n_out.last            = 1'b1;
                    case (i_in_data.kind)
                        KIND_INSERT: begin
                            if (w_full) begin
                                n_out.status = STAT_FULL;
                            end else begin
                                w_ctrl.op         = CELL_INSERT;
                                n_count           = r_count + 1'b1;
                                n_out.position    = 6'(w_ins_pos);
                                n_out.entry_count = 7'(r_count + 1'b1);
                            end
                        end
                        KIND_SEARCH, KIND_REMOVE: begin
                            if (!w_found) begin
                                n_out.status = STAT_NOT_FOUND;
                            end else begin
                                n_out.position = 6'(w_hit_pos);
                                if (i_in_data.kind == KIND_REMOVE) begin
                                    w_ctrl.op         = CELL_REMOVE;
                                    n_count           = r_count - 1'b1;
                                    n_out.entry_count = 7'(r_count - 1'b1);
                                end
                            end
                        end
                        KIND_DUMP: begin
                            if (r_count == '0) begin
                                n_out.status      = STAT_EMPTY;
                                n_out.entry_value = '0;
                            end else begin
                                // first beat leaves with the item itself
                                w_ctrl.op         = CELL_ROTATE;
                                n_out.entry_value = w_val[0];
                                n_out.last        = (w_lim == 1);
                                n_k               = CW'(1);
                                if (32'(r_count) != 1) begin
                                    n_state = S_DUMP;
                                end
                            end
                        end
                        default: begin
                            n_out = r_out;
                        end
                    endcase
                end
            end
            S_DUMP: begin
                if (!w_emit || w_out_free) begin
                    w_ctrl.op = CELL_ROTATE;
                    n_k       = r_k + 1'b1;
                    if (w_emit) begin
                        n_out_valid       = 1'b1;
                        n_out.status      = STAT_OK;
                        n_out.position    = 6'(r_k);
                        n_out.entry_value = w_val[0];
                        n_out.entry_count = 7'(r_count);
                        n_out.last        = (32'(r_k) + 1 == w_lim);
                    end
                    if (32'(r_k) + 1 == 32'(r_count)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ---- configuration port ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAPACITY_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == CFG_IDX_CAPACITY)) begin
            r_capacity <= pwdata[6:0];
        end
    end

    assign pready = 1'b1;

    always_comb begin
        prdata = '0;
        if (paddr[2] == CFG_IDX_CAPACITY) begin
            prdata = 32'(r_capacity);
        end
    end

endmodule

// File: sv/stc_checker.sv
// ----------------------------------------------------------------------------
// stc_checker
// Port-level checks of the sorted table core, bound to the top level.
// ----------------------------------------------------------------------------
module stc_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 o_in_ready,
    input  logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  stc_pkg::t_out_beat   o_out_data
);
    import stc_pkg::*;

    // a stalled result beat stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result beat dropped while stalled");

    // every accepted item shows a result beat in the next cycle
    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid)
        else $error("accepted item produced no result beat");

    // no item is taken while a result is held back
    a_no_take_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("item accepted while output stalled");

    // refusals and empty dumps are single beats
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != STAT_OK) |-> o_out_data.last
            && (o_out_data.position == '0))
        else $error("non-ok beat without last or with a position");

    // an empty dump reports nothing held
    a_empty_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == STAT_EMPTY) |->
            (o_out_data.entry_count == '0) && (o_out_data.entry_value == '0))
        else $error("empty dump beat carries data");

endmodule

bind sorted_table_insert_search_remove_core stc_checker u_stc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
